// ----- hw/rtl/esv_pkg.sv -----
`timescale 1ns / 1ps
package esv_pkg;
    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_RANGE    = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    localparam logic [1:0] REG_PRIME = 2'd0;
    localparam logic [1:0] REG_GEN   = 2'd1;
    localparam logic [1:0] REG_KEY   = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HRED,
        S_PSTART,
        S_PLOAD,
        S_MSTEP,
        S_MDONE,
        S_NEXT,
        S_CMP,
        S_OUT
    } t_state;
endpackage

// ----- hw/rtl/elgamal_signature_verifier_core.sv -----
`timescale 1ns / 1ps
// ElGamal signature checker. Write p, g and y over the APB port (0x0, 0x4,
// 0x8) while the block is idle. Each input item (r, s, 48-bit hash prefix)
// gives one status item: 0 valid, 1 r or s out of range, 2 mismatch.
// A range error goes from idle straight to the output state. Otherwise the
// hash prefix is first reduced modulo p-1 by restoring division, one
// quotient bit a cycle; then one bit-serial modular multiplier (one bit of
// the multiplier a cycle) does the exponentiations: g^H, y^r and r^s each
// take one product to reduce the base below p and up to 2*MOD_WIDTH
// products for the exponent bits, plus a final product of the last two.
// One item is in work at a time; the status waits in an output register,
// and the next item is taken once it has left.
module elgamal_signature_verifier_core
    import esv_pkg::*;
#(
    parameter int MOD_WIDTH = 32,
    parameter int HASH_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // fields low to high: sig_r, sig_s, hash_prefix
    input  logic [2*MOD_WIDTH+HASH_BITS-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // fields low to high: verify_status
    output logic [7:0]           m_axis_tdata
);
    localparam int W  = MOD_WIDTH;
    localparam int HB = HASH_BITS;
    localparam int CW = $clog2(W + HB + 2);

    // Registers are 32 bits on the APB side; wider moduli keep the upper bits zero.
    localparam int RW = (W < 32) ? W : 32;

    logic [W-1:0] r_p, r_g, r_y;
    logic [W-1:0] r_r, r_s;
    logic [HB-1:0] r_hq;       // dividend shifting out, msb first
    logic [W:0]    r_hrem;     // partial remainder
    logic [W-1:0] r_h;

    // exponentiation controls
    logic [1:0]   r_pw;        // 0: g^H, 1: y^r, 2: r^s, 3: final product
    logic [W-1:0] r_base, r_acc, r_exp;
    logic         r_phase;     // 0 multiply acc, 1 square base
    logic [W-1:0] r_rhs, r_t1;

    // serial multiplier
    logic [W-1:0] r_ma, r_mb;
    logic [W:0]   r_macc;
    logic [CW-1:0] r_cnt;

    logic [1:0]   r_stat;
    logic         r_ovld;
    t_state       r_st, n_st;

    wire cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_PRIME: prdata[RW-1:0] = r_p[RW-1:0];
            REG_GEN:   prdata[RW-1:0] = r_g[RW-1:0];
            REG_KEY:   prdata[RW-1:0] = r_y[RW-1:0];
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= W'(10631);
            r_g <= W'(11);
            r_y <= W'(1);
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_PRIME: r_p <= W'(pwdata[RW-1:0]);
                REG_GEN:   r_g <= W'(pwdata[RW-1:0]);
                REG_KEY:   r_y <= W'(pwdata[RW-1:0]);
                default:   ;
            endcase
        end
    end

    assign s_axis_tready = (r_st == S_IDLE) && !r_ovld;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = {6'd0, r_stat};

    wire [W-1:0] pm1 = r_p - W'(1);
    wire in_rng = (s_axis_tdata[W-1:0] != '0) && (s_axis_tdata[W-1:0] < r_p) &&
                  (s_axis_tdata[2*W-1:W] != '0) && (r_p >= W'(2)) &&
                  (s_axis_tdata[2*W-1:W] < pm1);

    // one reduction step: 2x+addend mod p, both below p
    wire [W:0] dbl   = {r_macc[W-1:0], 1'b0};
    wire [W:0] dbl_r = (dbl >= {1'b0, r_p}) ? dbl - {1'b0, r_p} : dbl;
    wire [W:0] add_v = dbl_r + (r_mb[W-1] ? {1'b0, r_ma} : '0);
    wire [W:0] add_r = (add_v >= {1'b0, r_p}) ? add_v - {1'b0, r_p} : add_v;

    // hash division step
    wire [W:0] hsh   = {r_hrem[W-1:0], r_hq[HB-1]};
    wire [W:0] hsub  = hsh - {1'b0, pm1};
    wire       hge   = (hsh >= {1'b0, pm1});

    // exponent used up: the square just done was the last one needed
    logic r_pre;  // base not yet reduced below p
    wire pw_done = (r_pw != 2'd3) && !r_pre && r_phase && (r_exp[W-1:1] == '0);

    // a base may be any W-bit value; the first pass feeds it through the
    // multiplier as 1*base, which folds it below p one bit at a time
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_IDLE:   if (s_axis_tvalid && s_axis_tready) n_st = in_rng ? S_HRED : S_OUT;
            S_HRED:   if (r_cnt == CW'(HB - 1)) n_st = S_PSTART;
            S_PSTART: n_st = S_PLOAD;
            S_PLOAD:  n_st = S_MSTEP;
            S_MSTEP:  if (r_cnt == CW'(W - 1)) n_st = S_MDONE;
            S_MDONE:  n_st = S_NEXT;
            S_NEXT:   n_st = (r_pw == 2'd3) ? S_CMP
                           : (pw_done ? S_PSTART : S_PLOAD);
            S_CMP:    n_st = S_OUT;
            S_OUT:    n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_IDLE;
            r_ovld <= 1'b0;
        end else begin
            r_st <= n_st;
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;
            if (r_st == S_OUT) r_ovld <= 1'b1;
        end
    end

    // datapath; r_pre tracks whether the reduction of the base is done.
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_r    <= s_axis_tdata[W-1:0];
                r_s    <= s_axis_tdata[2*W-1:W];
                r_hq   <= s_axis_tdata[2*W+HB-1:2*W];
                r_hrem <= '0;
                r_cnt  <= '0;
                r_pw   <= 2'd0;
                r_pre  <= 1'b1;
                // hold the waiting status until it has left
                if (s_axis_tready) r_stat <= ST_RANGE;
            end
            S_HRED: begin
                r_hrem <= hge ? hsub : hsh;
                r_hq   <= {r_hq[HB-2:0], 1'b0};
                r_cnt  <= r_cnt + CW'(1);
                if (r_cnt == CW'(HB - 1))
                    r_h <= ((hge ? hsub[W-1:0] : hsh[W-1:0]) == '0) ? W'(1)
                           : (hge ? hsub[W-1:0] : hsh[W-1:0]);
            end
            S_PSTART: begin
                // load base and exponent; first pass reduces base as 1*base
                r_pre <= 1'b1;
                unique case (r_pw)
                    2'd0: begin r_base <= r_g; r_exp <= r_h; r_acc <= W'(1); end
                    2'd1: begin r_base <= r_y; r_exp <= r_r; r_acc <= W'(1); end
                    2'd2: begin r_base <= r_r; r_exp <= r_s; r_acc <= W'(1); end
                    // final product: r^s stays in acc
                    default: begin r_base <= r_t1; r_exp <= '0; end
                endcase
                r_phase <= 1'b1;
            end
            S_PLOAD: begin
                r_macc <= '0;
                r_cnt  <= '0;
                if (r_pw == 2'd3) begin
                    r_ma <= r_base; r_mb <= r_acc;
                end else if (r_pre) begin
                    r_ma <= W'(1); r_mb <= r_base;
                end else if (!r_phase) begin
                    r_ma <= r_base; r_mb <= r_acc;
                end else begin
                    r_ma <= r_base; r_mb <= r_base;
                end
            end
            S_MSTEP: begin
                // ma is below p in every pass, so each step stays below p
                r_macc <= add_r;
                r_mb   <= {r_mb[W-2:0], 1'b0};
                r_cnt  <= r_cnt + CW'(1);
            end
            S_MDONE: ;
            S_NEXT: begin
                if (r_pw == 2'd3) begin
                    r_acc <= r_macc[W-1:0];
                end else if (pw_done) begin
                    // park the finished power and advance to the next one
                    unique case (r_pw)
                        2'd0: r_rhs <= r_acc;
                        2'd1: r_t1  <= r_acc;
                        default: ;
                    endcase
                    r_pw <= r_pw + 2'd1;
                end else if (r_pre) begin
                    r_base  <= r_macc[W-1:0];
                    r_pre   <= 1'b0;
                    r_phase <= !r_exp[0];
                end else if (!r_phase) begin
                    r_acc   <= r_macc[W-1:0];
                    r_phase <= 1'b1;
                end else begin
                    r_base  <= r_macc[W-1:0];
                    r_exp   <= r_exp >> 1;
                    r_phase <= !r_exp[1];
                end
            end
            S_CMP: r_stat <= (r_acc == r_rhs) ? ST_VALID : ST_MISMATCH;
            default: ;
        endcase
    end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
module tb;
    import esv_pkg::*;

    localparam int MW = 32;
    localparam int HW = 48;
    localparam logic [1:0] REG_SPARE = 2'd3;  // past the last register, ignored
    localparam int HOLD_CYCLES = 20000;

    typedef logic [MW-1:0] word_t;
    typedef logic [HW-1:0] hash_t;

    // Status predictor and queue of pending statuses, in order of acceptance.
    class status_board;
        word_t       mod_p, gen_g, key_y;
        logic [1:0]  pending[$];
        int          errors, checked;
        int          seen[3];

        function new();
            mod_p = 32'd10631;
            gen_g = 32'd11;
            key_y = 32'd1;
        endfunction

        function longint unsigned mulm(longint unsigned a, longint unsigned b,
                                       longint unsigned m);
            return ((a % m) * (b % m)) % m;
        endfunction

        function longint unsigned powm(longint unsigned b, longint unsigned e,
                                       longint unsigned m);
            longint unsigned acc;
            acc = 1 % m;
            b = b % m;
            while (e != 0) begin
                if (e[0]) acc = mulm(acc, b, m);
                b = mulm(b, b, m);
                e = e >> 1;
            end
            return acc;
        endfunction

        function logic [1:0] verify(word_t r, word_t s, hash_t hp);
            longint unsigned p, h, lhs, rhs;
            p = mod_p;
            if (r == 0 || r >= p || s == 0 || p < 3 || s >= p - 1) return ST_RANGE;
            h = hp % (p - 1);
            if (h == 0) h = 1;
            lhs = mulm(powm(key_y, r, p), powm(r, s, p), p);
            rhs = powm(gen_g, h, p);
            return (lhs == rhs) ? ST_VALID : ST_MISMATCH;
        endfunction

        function void note_item(word_t r, word_t s, hash_t hp);
            pending.push_back(verify(r, s, hp));
        endfunction

        function void check_status(logic [7:0] data);
            logic [1:0] want;
            if (pending.size() == 0) begin
                $error("verify_status: unexpected item %0d", data[1:0]);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (want <= ST_MISMATCH) seen[want]++;
            if (data[1:0] !== want || data[7:2] !== 6'd0) begin
                $error("verify_status: expected %0d, got %0d", want, data);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // fields low to high: sig_r, sig_s, hash_prefix
    logic [2*MW+HW-1:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // fields low to high: verify_status
    logic [7:0]   m_axis_tdata;

    status_board board = new();

    // Idle profile: percent of cycles the sender gaps and the receiver stalls.
    int send_idle = 0;
    int recv_stall = 0;
    int hold_off = 0;            // long receiver hold-off, counted down below
    logic hold_go = 1'b0;        // request for the hold-off
    logic hold_used = 1'b0;
    longint unsigned key_x = 0;  // secret exponent behind the current key
    int sent = 0;

    elgamal_signature_verifier_core dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #300ms;
        $display("tb: errors");
        $finish;
    end

    // Receiver: check each accepted status, then pick readiness for next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_status(m_axis_tdata);
        if (hold_go && !hold_used) begin
            hold_used <= 1'b1;
            hold_off <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall);
        end
    end

    // APB write: setup cycle, then access cycle.
    task automatic reg_write(logic [1:0] idx, word_t val);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_PRIME: board.mod_p = val;
            REG_GEN:   board.gen_g = val;
            REG_KEY:   board.key_y = val;
            default: ;
        endcase
    endtask

    // Hold the item until taken, then maybe leave a gap.
    task automatic send_sig(word_t r, word_t s, hash_t hp);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {hp, s, r};
        do @(posedge i_clk); while (!s_axis_tready);
        board.note_item(r, s, hp);
        sent++;
        if ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // New group: p, g, and a key derived from a fresh secret exponent.
    task automatic set_group(word_t p, word_t g, longint unsigned x);
        key_x = x;
        reg_write(REG_PRIME, p);
        reg_write(REG_GEN, g);
        reg_write(REG_KEY, (p > 1) ? word_t'(board.powm(g, x, p)) : word_t'(x));
    endtask

    // Build a signature that satisfies the equation: r = g^k, and
    // x*r + k*s = H mod p-1, with H lifted to a random 48-bit prefix.
    task automatic send_good();
        longint unsigned p, q, k, r, s, h, lifts;
        p = board.mod_p;
        q = p - 1;
        k = $urandom_range(1, (p > 6) ? 32'(p - 2) : 32'd1);
        r = board.powm(board.gen_g, k, p);
        s = $urandom_range(1, (p > 3) ? 32'(p - 2) : 32'd1);
        h = ((key_x % q) * (r % q) % q + (k % q) * (s % q) % q) % q;
        lifts = (64'hFFFF_FFFF_FFFF - h) / q;
        h = h + ({$urandom, $urandom} % (lifts + 1)) * q;
        send_sig(word_t'(r), word_t'(s), hash_t'(h));
    endtask

    task automatic send_random(int n);
        longint unsigned p;
        int pick;
        repeat (n) begin
            p = board.mod_p;
            pick = $urandom_range(99);
            if (pick < 70 && p > 4)
                send_good();
            else if (pick < 85 && p > 3)
                send_sig($urandom_range(1, 32'(p - 1)), $urandom_range(1, 32'(p - 2)),
                         hash_t'({$urandom, $urandom}));
            else
                send_sig($urandom, $urandom, hash_t'({$urandom, $urandom}));
        end
    endtask

    task automatic set_idle(int mode);
        case (mode % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 48; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 48; end
            default: begin send_idle = 13; recv_stall = 13; end
        endcase
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed on the reset group (p = 10631, g = 11, y = 1).
        send_sig(32'd0, 32'd5, 48'd7);             // r zero
        send_sig(32'd10631, 32'd5, 48'd7);         // r equal to p
        send_sig(32'd3, 32'd0, 48'd7);             // s zero
        send_sig(32'd3, 32'd10630, 48'd7);         // s equal to p-1
        send_sig(32'd10630, 32'd10629, 48'hFFFF_FFFF_FFFF);  // top of legal range
        send_sig(32'd1, 32'd1, 48'd0);             // hash zero, replaced by 1
        send_sig(32'd11, 32'd1, 48'd10630);        // hash reduces to zero
        send_sig(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_sig(32'd11, 32'd5, 48'd5);            // g^5 both sides, valid
        send_good();
        send_good();
        drain();

        // Smallest moduli: nothing passes the range check at p = 2 or 0; p = 3 admits r in 1..2 with s = 1.
        reg_write(REG_PRIME, 32'd2);
        send_sig(32'd1, 32'd1, 48'd1);
        drain();
        reg_write(REG_PRIME, 32'd0);
        send_sig(32'd1, 32'd1, 48'd1);
        drain();
        set_group(32'd3, 32'd2, 1);
        send_sig(32'd1, 32'd1, 48'd4);
        send_sig(32'd2, 32'd1, 48'd1);
        drain();

        // Generator and key not below p, and a write past the last register.
        reg_write(REG_PRIME, 32'd10007);
        reg_write(REG_GEN, 32'hFFFF_FFFF);
        reg_write(REG_KEY, 32'hFFFF_FFFF);
        reg_write(REG_SPARE, 32'hDEAD_BEEF);
        send_sig(32'd5, 32'd9, 48'h1234_5678_9ABC);
        send_sig(32'd10006, 32'd10005, 48'hFFFF_FFFF_FFFF);
        drain();

        // Largest 32-bit prime: full-length exponents, kept to a few items.
        set_group(32'hFFFF_FFFB, 32'd2, {$urandom, $urandom});
        send_good();
        send_good();
        send_sig(32'hFFFF_FFFA, 32'hFFFF_FFF9, 48'hFFFF_FFFF_FFFF);
        drain();

        // Random phases on modest groups, cycling through idle profiles.
        for (int ph = 0; ph < 8; ph++) begin
            set_idle(ph);
            case (ph % 4)
                0: set_group(32'd10631, 32'd11, $urandom_range(1, 10629));
                1: set_group(32'd65521, 32'd17, $urandom);
                2: set_group(32'd7, 32'd3, $urandom_range(1, 5));
                default: set_group(32'd1000003, 32'd2, $urandom);
            endcase
            // Long hold-off: the block fills and stalls its input meanwhile.
            if (ph == 3) hold_go <= 1'b1;
            send_random(11);
            drain();
        end

        // A short burst on the full-size prime with random stalls.
        set_idle(3);
        set_group(32'hFFFF_FFFB, 32'd5, {$urandom, $urandom});
        send_random(4);
        drain();

        $display("tb: %0d items sent, %0d statuses checked", sent, board.checked);
        $display("tb: valid %0d, range %0d, mismatch %0d",
                 board.seen[ST_VALID], board.seen[ST_RANGE], board.seen[ST_MISMATCH]);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
